>>> design/tec_pkg.sv
// Shared types, character codes and limits for the tab expand and compress block.
`timescale 1ns / 1ps

package tec_pkg;

    localparam int MAX_TAB     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int W_LIMIT     = (MAX_TAB < MAX_RESULTS) ? MAX_TAB : MAX_RESULTS;

    localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
    localparam logic [4:0] WIDTH_MAX       = 5'(W_LIMIT);

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0a;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] UTF_CONT    = 8'h80;
    localparam logic [7:0] UTF_LEAD2   = 8'hc0;
    localparam logic [7:0] UTF_LEAD3   = 8'he0;
    localparam logic [7:0] UTF_LEAD4   = 8'hf0;
    localparam logic [7:0] UTF_LEAD5   = 8'hf8;
    localparam logic [7:0] UTF_LEAD6   = 8'hfc;
    localparam logic [7:0] UTF_INVALID = 8'hfe;

    localparam logic REG_TAB_WIDTH = 1'b0;
    localparam logic REG_COMPRESS  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_res;

    typedef struct packed {
        logic [4:0] spaces;
        logic       has_tail;
        logic [7:0] tail;
    } t_run;

    typedef struct packed {
        logic [4:0] width;
        logic       compress;
        logic       clear;
    } t_cfg;

endpackage

>>> design/tec_line.sv
// Line state tracking and per-request run descriptor register.
`timescale 1ns / 1ps

module tec_line (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tec_pkg::t_cfg i_cfg,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  tec_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_run_valid,
    output tec_pkg::t_run o_run
);

    logic [3:0]    r_col, n_col;
    logic [2:0]    r_skip, n_skip;
    logic [3:0]    r_pend, n_pend;
    logic          r_lead, n_lead;
    logic          r_q_valid;
    tec_pkg::t_run r_q, n_run;

    logic       accept;
    logic [7:0] b;
    logic [4:0] w;
    logic [4:0] cnt;
    logic [2:0] skip_cut;
    logic [4:0] col_back;
    logic [4:0] sum1, diff1, sum2, diff2;
    logic [3:0] col_inc1, col_inc2;
    logic [4:0] pend_inc;
    logic [2:0] lead_skip;

    assign o_req_ready = !r_q_valid || i_take;
    assign accept      = i_req_valid && o_req_ready;
    assign o_run_valid = r_q_valid;
    assign o_run       = r_q;

    assign b        = i_req.in_byte;
    assign w        = i_cfg.width;
    assign cnt      = w - {1'b0, r_col};
    assign skip_cut = ({2'b00, r_skip} < cnt) ? r_skip : cnt[2:0];
    assign col_back = w - {2'b00, skip_cut};
    assign sum1     = {1'b0, r_col} + 5'd1;
    assign diff1    = sum1 - w;
    assign sum2     = {1'b0, r_col} + 5'd2;
    assign diff2    = sum2 - w;
    assign col_inc1 = (sum1 >= w) ? diff1[3:0] : sum1[3:0];
    assign col_inc2 = (w == 5'd1) ? 4'd0 : ((sum2 >= w) ? diff2[3:0] : sum2[3:0]);
    assign pend_inc = {1'b0, r_pend} + 5'd1;

    always_comb begin
        priority if (b < tec_pkg::UTF_LEAD3) begin
            lead_skip = 3'd1;
        end else if (b < tec_pkg::UTF_LEAD4) begin
            lead_skip = 3'd2;
        end else if (b < tec_pkg::UTF_LEAD5) begin
            lead_skip = 3'd3;
        end else if (b < tec_pkg::UTF_LEAD6) begin
            lead_skip = 3'd4;
        end else begin
            lead_skip = 3'd5;
        end
    end

    always_comb begin
        n_col  = r_col;
        n_skip = r_skip;
        n_pend = r_pend;
        n_lead = r_lead;
        n_run  = '{spaces: 5'd0, has_tail: 1'b1, tail: b};
        if (!i_cfg.compress) begin
            priority if (b == tec_pkg::CH_NL) begin
                n_col  = 4'd0;
                n_skip = 3'd0;
            end else if (b == tec_pkg::CH_TAB) begin
                n_run.spaces   = cnt;
                n_run.has_tail = 1'b0;
                n_skip         = r_skip - skip_cut;
                n_col          = (skip_cut == 3'd0) ? 4'd0 : col_back[3:0];
            end else if (r_skip != 3'd0) begin
                n_skip = r_skip - 3'd1;
            end else if (b < tec_pkg::UTF_CONT) begin
                n_col = col_inc1;
            end else if (b < tec_pkg::UTF_LEAD2 || b >= tec_pkg::UTF_INVALID) begin
                n_col = r_col;
            end else begin
                n_col  = col_inc2;
                n_skip = lead_skip;
            end
        end else begin
            priority if (b == tec_pkg::CH_NL) begin
                n_run.spaces = {1'b0, r_pend};
                n_col        = 4'd0;
                n_skip       = 3'd0;
                n_pend       = 4'd0;
                n_lead       = 1'b1;
            end else if (!r_lead) begin
                n_run.spaces = 5'd0;
            end else if (b == tec_pkg::CH_SP) begin
                if (pend_inc >= w) begin
                    n_pend     = 4'd0;
                    n_run.tail = tec_pkg::CH_TAB;
                end else begin
                    n_pend         = pend_inc[3:0];
                    n_run.has_tail = 1'b0;
                    n_run.spaces   = i_req.end_of_text ? pend_inc : 5'd0;
                end
            end else if (b == tec_pkg::CH_TAB) begin
                n_run.spaces = {1'b0, r_pend};
                n_pend       = 4'd0;
            end else begin
                n_run.spaces = {1'b0, r_pend};
                n_pend       = 4'd0;
                n_lead       = 1'b0;
            end
        end
        if (i_req.end_of_text) begin
            n_col  = 4'd0;
            n_skip = 3'd0;
            n_pend = 4'd0;
            n_lead = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= 4'd0;
            r_skip    <= 3'd0;
            r_pend    <= 4'd0;
            r_lead    <= 1'b1;
            r_q_valid <= 1'b0;
        end else begin
            if (accept && !i_cfg.clear) begin
                r_q_valid <= (n_run.spaces != 5'd0) || n_run.has_tail;
            end else if (i_take) begin
                r_q_valid <= 1'b0;
            end
            if (i_cfg.clear) begin
                r_col  <= 4'd0;
                r_skip <= 3'd0;
                r_pend <= 4'd0;
                r_lead <= 1'b1;
            end else if (accept) begin
                r_col  <= n_col;
                r_skip <= n_skip;
                r_pend <= n_pend;
                r_lead <= n_lead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= n_run;
        end
    end

endmodule

>>> design/tec_emit.sv
// Result emitter that plays out one run of spaces and an optional closing byte.
`timescale 1ns / 1ps

module tec_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run_valid,
    input  tec_pkg::t_run i_run,
    output logic          o_take,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output tec_pkg::t_res o_res
);

    logic       r_busy;
    logic [4:0] r_spaces;
    logic       r_has_tail;
    logic [7:0] r_tail;
    logic       last;
    logic       load;

    assign last   = (r_spaces == 5'd0) || (r_spaces == 5'd1 && !r_has_tail);
    assign o_take = !r_busy || (i_res_ready && last);
    assign load   = o_take && i_run_valid;

    assign o_res_valid       = r_busy;
    assign o_res.out_byte    = (r_spaces != 5'd0) ? tec_pkg::CH_SP : r_tail;
    assign o_res.last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_spaces <= 5'd0;
        end else if (load) begin
            r_busy   <= 1'b1;
            r_spaces <= i_run.spaces;
        end else if (r_busy && i_res_ready) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_spaces <= r_spaces - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_has_tail <= i_run.has_tail;
            r_tail     <= i_run.tail;
        end
    end

endmodule

>>> design/tab_expand_compress.sv
// Top level of the tab expander and leading-space compressor with its register port.
// The first result of a request is offered once its run is registered in tec_line and loaded into the emitter.
// Throughput: one result per cycle while the receiver is ready; a request giving k results holds the emitter for all k.
// Requests are taken every cycle while each gives one result and results are taken, one request buffered ahead.
// Reset is synchronous: tab width 4, expand mode, line state cleared, no results pending.
`timescale 1ns / 1ps

module tab_expand_compress (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  tec_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output tec_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [4:0]    r_tab_width;
    logic          r_compress;
    logic          wr_en;
    logic [4:0]    eff_width;
    tec_pkg::t_cfg cfg;
    logic          take;
    logic          run_valid;
    tec_pkg::t_run run;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            tec_pkg::REG_TAB_WIDTH: prdata = {27'd0, r_tab_width};
            tec_pkg::REG_COMPRESS:  prdata = {31'd0, r_compress};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= tec_pkg::TAB_WIDTH_RESET;
            r_compress  <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                tec_pkg::REG_TAB_WIDTH: r_tab_width <= pwdata[4:0];
                tec_pkg::REG_COMPRESS:  r_compress  <= pwdata[0];
                default:                r_compress  <= r_compress;
            endcase
        end
    end

    assign eff_width = (r_tab_width == 5'd0) ? 5'd1 :
                       ((r_tab_width > tec_pkg::WIDTH_MAX) ? tec_pkg::WIDTH_MAX : r_tab_width);

    assign cfg = '{width: eff_width, compress: r_compress, clear: wr_en};

    tec_line u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_take      (take),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    tec_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_take      (take),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    // Only the final result of a request can be anything other than a space.
    a_space_before_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last_of_run) |-> (o_res.out_byte == tec_pkg::CH_SP))
        else $error("non-final result is not a space");

    // A run that is not finished keeps the output valid after a result is taken.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && !o_res.last_of_run) |=> o_res_valid)
        else $error("run ended before its final result");

    // No result is offered straight after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // A buffered run is never dropped while the emitter cannot take it.
    a_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run_valid && !take) |=> run_valid)
        else $error("buffered run lost");

endmodule
